>>> sv/spg_pkg.sv
package spg_pkg;

  localparam int SPEED_W = 13;
  localparam int DIST_W  = 16;
  localparam int HOLD_W  = 8;
  localparam int GAP_W   = 16;
  localparam int SCALE_W = 10;
  localparam int VEL_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // The interpolation product is |max - min| * (d - near).
  localparam int PROD_W = SPEED_W + DIST_W;
  // Scaled target before the Q2.8 shift.
  localparam int SCALED_W = SPEED_W + SCALE_W;
  // The quotient is below |max - min|, so it has SPEED_W bits.
  localparam int QUO_W = SPEED_W;
  localparam int CNT_W = 4;

  localparam logic [SPEED_W-1:0] STOP_SPEED_DEFAULT = '0;
  localparam logic [SPEED_W-1:0] ACCEL_NO_RAMP = '1;

  localparam logic [SPEED_W-1:0] RST_MAX_SPEED  = 13'd1000;
  localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 13'd1000;
  localparam logic [DIST_W-1:0]  RST_STOP_DIST  = 16'd200;
  localparam logic [DIST_W-1:0]  RST_NEAR_DIST  = 16'd300;
  localparam logic [DIST_W-1:0]  RST_FAR_DIST   = 16'd1000;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS = 8'd1;
  localparam logic [GAP_W-1:0]   RST_GAP_TICKS  = 16'd2;
  localparam logic [SPEED_W-1:0] RST_ACCEL_STEP = 13'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED  = 3'd0,
    REG_MIN_SPEED  = 3'd1,
    REG_STOP_DIST  = 3'd2,
    REG_NEAR_DIST  = 3'd3,
    REG_FAR_DIST   = 3'd4,
    REG_HOLD_TICKS = 3'd5,
    REG_GAP_TICKS  = 3'd6,
    REG_ACCEL_STEP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] min_speed;
    logic [DIST_W-1:0]  stop_distance;
    logic [DIST_W-1:0]  near_slowdown_distance;
    logic [DIST_W-1:0]  far_slowdown_distance;
    logic [HOLD_W-1:0]  stop_hold_ticks;
    logic [GAP_W-1:0]   stop_gap_ticks;
    logic [SPEED_W-1:0] accel_step;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DECIDE,
    OP_MUL,
    OP_DIV,
    OP_BAND,
    OP_SCALE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_NO_INPUT,
    C_DIRECT,
    C_DIV_MORE,
    C_OUT_BUSY,
    C_ALWAYS
  } cond_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    op_t  op;
    logic in_fire;
    logic emit_fire;
  } ctl_t;

  typedef struct packed {
    logic direct;
    logic div_more;
  } status_t;

  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_DIV   = 3'd3;
  localparam step_t STEP_SCALE = 3'd5;
  localparam step_t STEP_EMIT  = 3'd6;

  // Microprogram: a taken condition jumps to target, otherwise the next step.
  function automatic ctrl_word_t ucode(step_t pc);
    ctrl_word_t w;
    case (pc)
      3'd0:    w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: STEP_LOAD};
      3'd1:    w = '{op: OP_DECIDE, cond: C_DIRECT,   target: STEP_SCALE};
      3'd2:    w = '{op: OP_MUL,    cond: C_NEXT,     target: STEP_LOAD};
      3'd3:    w = '{op: OP_DIV,    cond: C_DIV_MORE, target: STEP_DIV};
      3'd4:    w = '{op: OP_BAND,   cond: C_NEXT,     target: STEP_LOAD};
      3'd5:    w = '{op: OP_SCALE,  cond: C_NEXT,     target: STEP_LOAD};
      3'd6:    w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: STEP_EMIT};
      default: w = '{op: OP_NOP,    cond: C_ALWAYS,   target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> sv/spg_if.sv
interface spg_tick_if import spg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  bend_distance;
  logic [SCALE_W-1:0] speed_scale;
  logic               track_found;
  logic               at_goal;

  modport source (output valid, bend_distance, speed_scale, track_found, at_goal,
                  input ready);
  modport sink (input valid, bend_distance, speed_scale, track_found, at_goal,
                output ready);
endinterface

interface spg_result_if import spg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VEL_W-1:0] velocity_cmd;
  logic [VEL_W-1:0] expected_speed;
  logic             stopping;

  modport source (output valid, velocity_cmd, expected_speed, stopping, input ready);
  modport sink (input valid, velocity_cmd, expected_speed, stopping, output ready);
endinterface

interface spg_cfg_if import spg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/spg_datapath.sv
module spg_datapath import spg_pkg::*; #(
  parameter logic [SPEED_W-1:0] STOP_SPEED = STOP_SPEED_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic [DIST_W-1:0]  bend_distance,
  input  logic [SCALE_W-1:0] speed_scale,
  input  logic               track_found,
  input  logic               at_goal,
  input  cfg_t               cfg,
  output status_t            status,
  output logic [VEL_W-1:0]   velocity_cmd,
  output logic [VEL_W-1:0]   expected_speed,
  output logic               stopping
);

  logic [DIST_W-1:0]   bend;
  logic [SCALE_W-1:0]  scale;
  logic                found;
  logic                goal;
  logic [GAP_W-1:0]    ticks_since_stop;
  logic [HOLD_W-1:0]   hold_left;
  logic [SPEED_W-1:0]  target;
  logic                stop_flag;
  logic                falling;
  logic [DIST_W-1:0]   span;
  logic [DIST_W-1:0]   rem;
  logic [QUO_W-1:0]    quo;
  logic [CNT_W-1:0]    cnt;
  logic [SCALED_W-1:0] scaled;
  logic [VEL_W-1:0]    velocity;

  logic [GAP_W-1:0]    tick_inc;
  logic                hold_busy;
  logic                stop_start;
  logic                beyond;
  logic                below;
  logic                neg_w;
  logic [SPEED_W-1:0]  mag;
  logic [DIST_W-1:0]   off;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W:0]     trial;
  logic [DIST_W:0]     trial_sub;
  logic                trial_ge;
  logic [SPEED_W-1:0]  band;
  logic [VEL_W-1:0]    expected;
  logic [VEL_W:0]      up;
  logic [VEL_W-1:0]    velocity_next;

  assign tick_inc  = (ticks_since_stop == '1) ? ticks_since_stop : ticks_since_stop + 1'b1;
  assign hold_busy = (hold_left != '0);
  assign stop_start = (bend < cfg.stop_distance) && (ticks_since_stop > cfg.stop_gap_ticks)
                      && (cfg.stop_hold_ticks != '0);
  assign beyond = (bend >= cfg.far_slowdown_distance);
  assign below  = (bend <= cfg.near_slowdown_distance);

  assign status.direct   = hold_busy || stop_start || beyond || below;
  assign status.div_more = (cnt > CNT_W'(1));

  // Interpolation runs on the magnitude of max - min; the sign is put back after
  // the division, which matches truncation toward zero.
  assign neg_w = (cfg.max_speed < cfg.min_speed);
  assign mag   = neg_w ? cfg.min_speed - cfg.max_speed : cfg.max_speed - cfg.min_speed;
  assign off   = bend - cfg.near_slowdown_distance;
  assign prod  = PROD_W'(mag) * PROD_W'(off);

  // Restoring division, one quotient bit per cycle.
  assign trial     = {rem, quo[QUO_W-1]};
  assign trial_ge  = (trial >= {1'b0, span});
  assign trial_sub = trial - {1'b0, span};

  assign band = falling ? cfg.min_speed - quo : cfg.min_speed + quo;

  assign expected = scaled[SCALED_W-1:8];
  assign up       = {1'b0, velocity} + (VEL_W+1)'(cfg.accel_step);

  always_comb begin
    velocity_next = velocity;
    if (found && !goal) begin
      if (cfg.accel_step == ACCEL_NO_RAMP || expected < velocity) begin
        velocity_next = expected;
      end else if (up < {1'b0, expected}) begin
        velocity_next = up[VEL_W-1:0];
      end else begin
        velocity_next = expected;
      end
    end
    if (goal) begin
      velocity_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_stop <= '1;
      hold_left        <= '0;
      velocity         <= '0;
      cnt              <= '0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          if (ctl.in_fire) begin
            bend             <= bend_distance;
            scale            <= speed_scale;
            found            <= track_found;
            goal             <= at_goal;
            ticks_since_stop <= tick_inc;
          end
        end
        OP_DECIDE: begin
          stop_flag <= hold_busy || stop_start;
          if (hold_busy) begin
            target    <= STOP_SPEED;
            hold_left <= hold_left - 1'b1;
          end else if (stop_start) begin
            target           <= STOP_SPEED;
            ticks_since_stop <= '0;
            hold_left        <= cfg.stop_hold_ticks - 1'b1;
          end else if (beyond) begin
            target <= cfg.max_speed;
          end else if (below) begin
            target <= cfg.min_speed;
          end
        end
        OP_MUL: begin
          // The product is below |max - min| * span, so its high part is below span.
          falling <= neg_w;
          span    <= cfg.far_slowdown_distance - cfg.near_slowdown_distance;
          rem     <= prod[PROD_W-1:QUO_W];
          quo     <= prod[QUO_W-1:0];
          cnt     <= CNT_W'(QUO_W);
        end
        OP_DIV: begin
          rem <= trial_ge ? trial_sub[DIST_W-1:0] : trial[DIST_W-1:0];
          quo <= {quo[QUO_W-2:0], trial_ge};
          cnt <= cnt - 1'b1;
        end
        OP_BAND: begin
          target <= band;
        end
        OP_SCALE: begin
          scaled <= SCALED_W'(target) * SCALED_W'(scale);
        end
        OP_EMIT: begin
          if (ctl.emit_fire) begin
            velocity <= velocity_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign velocity_cmd   = velocity_next;
  assign expected_speed = expected;
  assign stopping       = stop_flag;

endmodule

>>> sv/speed_profile_governor.sv
// A word taken at the input passes the steps load, decide, scale and emit when the target
// needs no interpolation (stop, held stop, outside the band); inside it, the steps multiply,
// divide and band come between decide and scale, the 13-step serial divider looping on divide.
// The sequencer takes no new word before it has emitted the last; emit waits on a full output.
// Reset (synchronous, rst high) loads the register defaults, clears velocity and hold,
// sets the tick counter to all ones and empties the output register.
module speed_profile_governor import spg_pkg::*; #(
  parameter logic [SPEED_W-1:0] STOP_SPEED = STOP_SPEED_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  spg_tick_if.sink     tick,
  spg_result_if.source result,
  spg_cfg_if.sink      cfg
);

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t cw;
  logic       jump;
  logic       out_busy;
  ctl_t       ctl;
  status_t    status;
  cfg_t       regs;

  logic [VEL_W-1:0] dp_velocity;
  logic [VEL_W-1:0] dp_expected;
  logic             dp_stopping;

  assign cw       = ucode(pc);
  assign out_busy = result.valid && !result.ready;

  assign ctl.op        = cw.op;
  assign ctl.in_fire   = (cw.op == OP_LOAD) && tick.valid;
  assign ctl.emit_fire = (cw.op == OP_EMIT) && !out_busy;

  assign tick.ready = (cw.op == OP_LOAD);
  assign cfg.ready  = 1'b1;

  always_comb begin
    case (cw.cond)
      C_NEXT:     jump = 1'b0;
      C_NO_INPUT: jump = !tick.valid;
      C_DIRECT:   jump = status.direct;
      C_DIV_MORE: jump = status.div_more;
      C_OUT_BUSY: jump = out_busy;
      C_ALWAYS:   jump = 1'b1;
      default:    jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_speed              <= RST_MAX_SPEED;
      regs.min_speed              <= RST_MIN_SPEED;
      regs.stop_distance          <= RST_STOP_DIST;
      regs.near_slowdown_distance <= RST_NEAR_DIST;
      regs.far_slowdown_distance  <= RST_FAR_DIST;
      regs.stop_hold_ticks        <= RST_HOLD_TICKS;
      regs.stop_gap_ticks         <= RST_GAP_TICKS;
      regs.accel_step             <= RST_ACCEL_STEP;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_MAX_SPEED:  regs.max_speed              <= cfg.data[SPEED_W-1:0];
        REG_MIN_SPEED:  regs.min_speed              <= cfg.data[SPEED_W-1:0];
        REG_STOP_DIST:  regs.stop_distance          <= cfg.data[DIST_W-1:0];
        REG_NEAR_DIST:  regs.near_slowdown_distance <= cfg.data[DIST_W-1:0];
        REG_FAR_DIST:   regs.far_slowdown_distance  <= cfg.data[DIST_W-1:0];
        REG_HOLD_TICKS: regs.stop_hold_ticks        <= cfg.data[HOLD_W-1:0];
        REG_GAP_TICKS:  regs.stop_gap_ticks         <= cfg.data[GAP_W-1:0];
        REG_ACCEL_STEP: regs.accel_step             <= cfg.data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spg_datapath #(
    .STOP_SPEED(STOP_SPEED)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .bend_distance (tick.bend_distance),
    .speed_scale   (tick.speed_scale),
    .track_found   (tick.track_found),
    .at_goal       (tick.at_goal),
    .cfg           (regs),
    .status        (status),
    .velocity_cmd  (dp_velocity),
    .expected_speed(dp_expected),
    .stopping      (dp_stopping)
  );

  // The output register holds a finished word while the sequencer takes the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.emit_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_fire) begin
      result.velocity_cmd   <= dp_velocity;
      result.expected_speed <= dp_expected;
      result.stopping       <= dp_stopping;
    end
  end

endmodule

>>> verif/tb_speed_profile_governor.sv
module tb_speed_profile_governor;
  import spg_pkg::*;

  localparam logic [SPEED_W-1:0] STOP_SPD = STOP_SPEED_DEFAULT;
  localparam int SETTLE_CYCLES = 25;
  localparam int LONG_STALL = 400;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic [VEL_W-1:0] vel;
    logic [VEL_W-1:0] spd;
    logic             stop;
  } speed_word_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [DIST_W-1:0]  bend;
    logic [SCALE_W-1:0] scale;
    logic               found;
    logic               goal;
    logic               pinned;
    speed_word_t        word;
  } dir_row_t;

  // Phase 0 runs on the reset register values; its words can be worked out by hand.
  localparam cfg_t DIR_CFGS [4] = '{
    '{RST_MAX_SPEED, RST_MIN_SPEED, RST_STOP_DIST, RST_NEAR_DIST, RST_FAR_DIST,
      RST_HOLD_TICKS, RST_GAP_TICKS, RST_ACCEL_STEP},
    '{13'd8191, 13'd0, 16'd65535, 16'd0, 16'd65535, 8'd3, 16'd0, 13'd8191},
    '{13'd0, 13'd8191, 16'd0, 16'd5000, 16'd100, 8'd0, 16'd65535, 13'd0},
    '{13'd100, 13'd8000, 16'd500, 16'd1000, 16'd9000, 8'd2, 16'd5, 13'd1000}
  };

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{2'd0, 16'd65535, 10'd256,  1'b1, 1'b0, 1'b1, '{15'd500,  15'd1000, 1'b0}},
    '{2'd0, 16'd65535, 10'd256,  1'b1, 1'b0, 1'b1, '{15'd1000, 15'd1000, 1'b0}},
    '{2'd0, 16'd0,     10'd256,  1'b1, 1'b0, 1'b1, '{15'd0,    15'd0,    1'b1}},
    '{2'd0, 16'd0,     10'd256,  1'b1, 1'b0, 1'b1, '{15'd500,  15'd1000, 1'b0}},
    '{2'd0, 16'd0,     10'd256,  1'b1, 1'b0, 1'b1, '{15'd1000, 15'd1000, 1'b0}},
    '{2'd0, 16'd0,     10'd256,  1'b1, 1'b0, 1'b1, '{15'd0,    15'd0,    1'b1}},
    '{2'd0, 16'd65535, 10'd1023, 1'b0, 1'b0, 1'b1, '{15'd0,    15'd3996, 1'b0}},
    '{2'd0, 16'd65535, 10'd1023, 1'b1, 1'b1, 1'b1, '{15'd0,    15'd3996, 1'b0}},
    '{2'd0, 16'd65535, 10'd0,    1'b1, 1'b0, 1'b1, '{15'd0,    15'd0,    1'b0}},
    '{2'd0, 16'd65535, 10'd1023, 1'b1, 1'b0, 1'b1, '{15'd500,  15'd3996, 1'b0}},
    '{2'd0, 16'd500,   10'd512,  1'b1, 1'b0, 1'b1, '{15'd1000, 15'd2000, 1'b0}},
    '{2'd0, 16'd199,   10'd256,  1'b1, 1'b0, 1'b1, '{15'd0,    15'd0,    1'b1}},
    '{2'd1, 16'd65535, 10'd1023, 1'b1, 1'b0, 1'b0, '0},
    '{2'd1, 16'd32768, 10'd256,  1'b1, 1'b0, 1'b0, '0},
    '{2'd1, 16'd1,     10'd1023, 1'b1, 1'b0, 1'b0, '0},
    '{2'd1, 16'd40000, 10'd700,  1'b1, 1'b0, 1'b0, '0},
    '{2'd1, 16'd0,     10'd256,  1'b1, 1'b0, 1'b0, '0},
    '{2'd2, 16'd99,    10'd256,  1'b1, 1'b0, 1'b0, '0},
    '{2'd2, 16'd100,   10'd1023, 1'b1, 1'b0, 1'b0, '0},
    '{2'd2, 16'd65535, 10'd512,  1'b1, 1'b0, 1'b0, '0},
    '{2'd2, 16'd0,     10'd1023, 1'b0, 1'b1, 1'b0, '0},
    '{2'd3, 16'd9000,  10'd256,  1'b1, 1'b0, 1'b0, '0},
    '{2'd3, 16'd5000,  10'd256,  1'b1, 1'b0, 1'b0, '0},
    '{2'd3, 16'd1001,  10'd300,  1'b1, 1'b0, 1'b0, '0},
    '{2'd3, 16'd400,   10'd256,  1'b1, 1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  spg_tick_if   tick_ch ();
  spg_result_if res_ch ();
  spg_cfg_if    cfg_ch ();

  speed_profile_governor #(.STOP_SPEED(STOP_SPD)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copy.
  cfg_t                gov_cfg;
  logic [VEL_W-1:0]    vel_now;
  logic [HOLD_W-1:0]   hold_cnt;
  logic [GAP_W-1:0]    since_stop_cnt;
  speed_word_t         pending_words [$];

  logic                pin_flag;
  speed_word_t         pin_word;
  int                  n_errors = 0;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  logic                stall_req = 1'b0;
  logic                stall_ack = 1'b0;
  int unsigned         rx_stall_left = 0;
  speed_word_t         got_word;
  speed_word_t         want_word;
  speed_word_t         next_word;

  function automatic logic [SPEED_W-1:0] slowdown_target(input logic [DIST_W-1:0] d);
    longint lo, hi, span, off;
    if (d >= gov_cfg.far_slowdown_distance) return gov_cfg.max_speed;
    if (d <= gov_cfg.near_slowdown_distance) return gov_cfg.min_speed;
    lo = longint'(gov_cfg.min_speed);
    hi = longint'(gov_cfg.max_speed);
    span = longint'(gov_cfg.far_slowdown_distance) - longint'(gov_cfg.near_slowdown_distance);
    off = longint'(d) - longint'(gov_cfg.near_slowdown_distance);
    // Signed division truncates toward zero, which a falling ramp relies on.
    return SPEED_W'(lo + ((hi - lo) * off) / span);
  endfunction

  function automatic speed_word_t govern_tick(input logic [DIST_W-1:0] d,
                                              input logic [SCALE_W-1:0] sc,
                                              input logic found, input logic goal);
    logic [SPEED_W-1:0]  target;
    logic [SCALED_W-1:0] prod;
    logic [VEL_W-1:0]    spd;
    logic [VEL_W+1:0]    up;
    speed_word_t         w;
    w.stop = 1'b0;
    if (since_stop_cnt != '1) since_stop_cnt = since_stop_cnt + 1'b1;
    if (hold_cnt != '0) begin
      target = STOP_SPD;
      hold_cnt = hold_cnt - 1'b1;
      w.stop = 1'b1;
    end else if (d < gov_cfg.stop_distance && since_stop_cnt > gov_cfg.stop_gap_ticks &&
                 gov_cfg.stop_hold_ticks != '0) begin
      target = STOP_SPD;
      since_stop_cnt = '0;
      hold_cnt = gov_cfg.stop_hold_ticks - 1'b1;
      w.stop = 1'b1;
    end else begin
      target = slowdown_target(d);
    end
    prod = target * sc;
    spd = ((prod >> 8) > SCALED_W'(32767)) ? VEL_W'(32767) : VEL_W'(prod >> 8);
    if (found && !goal) begin
      if (gov_cfg.accel_step == ACCEL_NO_RAMP || spd < vel_now) begin
        vel_now = spd;
      end else begin
        up = vel_now + gov_cfg.accel_step;
        vel_now = (up < spd) ? VEL_W'(up) : spd;
      end
    end
    if (goal) vel_now = '0;
    w.vel = vel_now;
    w.spd = spd;
    return w;
  endfunction

  function automatic logic [SPEED_W-1:0] speed_pick();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SPEED_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int unsigned n;
    c.max_speed = speed_pick();
    c.min_speed = speed_pick();
    c.stop_distance = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
    n = $urandom_range(0, 2500);
    c.near_slowdown_distance = 16'(n);
    // Now and then the band is reversed or empty.
    c.far_slowdown_distance = ($urandom_range(9) == 0) ? 16'($urandom_range(0, n)) :
                              16'(n + $urandom_range(1, 4000));
    c.stop_hold_ticks = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    c.stop_gap_ticks = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    case ($urandom_range(7))
      0: c.accel_step = '0;
      1: c.accel_step = ACCEL_NO_RAMP;
      default: c.accel_step = SPEED_W'($urandom_range(1, 1500));
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Bits above a register's width are random; the block must drop them.
  task automatic write_all(input cfg_t c);
    write_reg(REG_MAX_SPEED,  {3'($urandom), c.max_speed});
    write_reg(REG_MIN_SPEED,  {3'($urandom), c.min_speed});
    write_reg(REG_STOP_DIST,  c.stop_distance);
    write_reg(REG_NEAR_DIST,  c.near_slowdown_distance);
    write_reg(REG_FAR_DIST,   c.far_slowdown_distance);
    write_reg(REG_HOLD_TICKS, {8'($urandom), c.stop_hold_ticks});
    write_reg(REG_GAP_TICKS,  c.stop_gap_ticks);
    write_reg(REG_ACCEL_STEP, {3'($urandom), c.accel_step});
  endtask

  // One edge first, so that the word accepted at the last edge is already queued.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick(input logic [DIST_W-1:0] d, input logic [SCALE_W-1:0] sc,
                           input logic found, input logic goal,
                           input logic pin, input speed_word_t pw);
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.bend_distance <= d;
    tick_ch.speed_scale   <= sc;
    tick_ch.track_found   <= found;
    tick_ch.at_goal       <= goal;
    pin_flag              <= pin;
    pin_word              <= pw;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
  endtask

  always @(posedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack     <= stall_req;
      rx_stall_left <= LONG_STALL;
      res_ch.ready  <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        got_word = '{res_ch.velocity_cmd, res_ch.expected_speed, res_ch.stopping};
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: vel %0d spd %0d",
                                    got_word.vel, got_word.spd));
        end else begin
          want_word = pending_words.pop_front();
          if (got_word.vel !== want_word.vel)
            report_mismatch($sformatf("velocity_cmd %0d, expected %0d",
                                      got_word.vel, want_word.vel));
          if (got_word.spd !== want_word.spd)
            report_mismatch($sformatf("expected_speed %0d, expected %0d",
                                      got_word.spd, want_word.spd));
          if (got_word.stop !== want_word.stop)
            report_mismatch($sformatf("stopping %0b, expected %0b",
                                      got_word.stop, want_word.stop));
        end
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_MAX_SPEED:  gov_cfg.max_speed = cfg_ch.data[SPEED_W-1:0];
          REG_MIN_SPEED:  gov_cfg.min_speed = cfg_ch.data[SPEED_W-1:0];
          REG_STOP_DIST:  gov_cfg.stop_distance = cfg_ch.data[DIST_W-1:0];
          REG_NEAR_DIST:  gov_cfg.near_slowdown_distance = cfg_ch.data[DIST_W-1:0];
          REG_FAR_DIST:   gov_cfg.far_slowdown_distance = cfg_ch.data[DIST_W-1:0];
          REG_HOLD_TICKS: gov_cfg.stop_hold_ticks = cfg_ch.data[HOLD_W-1:0];
          REG_GAP_TICKS:  gov_cfg.stop_gap_ticks = cfg_ch.data[GAP_W-1:0];
          REG_ACCEL_STEP: gov_cfg.accel_step = cfg_ch.data[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) begin
        next_word = govern_tick(tick_ch.bend_distance, tick_ch.speed_scale,
                                tick_ch.track_found, tick_ch.at_goal);
        // A hand-written word stands in for the prediction, so the two cross-check.
        pending_words = {pending_words, (pin_flag ? pin_word : next_word)};
      end
    end
  end

  initial begin
    int unsigned approach_d;
    int unsigned reach;
    logic [DIST_W-1:0]  d;
    logic [SCALE_W-1:0] sc;
    logic [1:0]         cur_phase;
    cfg_t               c;

    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.bend_distance = '0;
    tick_ch.speed_scale = '0;
    tick_ch.track_found = 1'b0;
    tick_ch.at_goal = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_SPEED;
    cfg_ch.data = '0;
    pin_flag = 1'b0;
    pin_word = '0;
    gov_cfg = DIR_CFGS[0];
    vel_now = '0;
    hold_cnt = '0;
    since_stop_cnt = '1;
    tx_idle_pct = 10;
    rx_idle_pct = 77;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cur_phase = 2'd0;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].phase != cur_phase) begin
        settle();
        cur_phase = DIR_ROWS[i].phase;
        write_all(DIR_CFGS[cur_phase]);
      end
      send_tick(DIR_ROWS[i].bend, DIR_ROWS[i].scale, DIR_ROWS[i].found, DIR_ROWS[i].goal,
                DIR_ROWS[i].pinned, DIR_ROWS[i].word);
    end
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 6) begin
        tx_idle_pct = 10;
        rx_idle_pct = 77;
      end else if (ph < 11) begin
        tx_idle_pct = 77;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 3) c = '1;
      else if (ph == 4) c = '0;
      else c = rand_cfg();
      write_all(c);
      approach_d = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 12 && k == 20) stall_req <= ~stall_req;
        if (ph == 13 && k == 50) settle();
        // Mostly a robot closing in on a bend, with stray and edge distances mixed in.
        case ($urandom_range(19))
          0, 1, 2: d = 16'($urandom);
          3, 4: begin
            case ($urandom_range(3))
              0: d = gov_cfg.stop_distance - 1'b1;
              1: d = gov_cfg.stop_distance;
              2: d = gov_cfg.near_slowdown_distance + 16'($urandom_range(0, 1));
              default: d = gov_cfg.far_slowdown_distance - 16'($urandom_range(0, 1));
            endcase
          end
          default: begin
            reach = $urandom_range(1, 400);
            if (approach_d < reach) begin
              approach_d = gov_cfg.far_slowdown_distance + $urandom_range(0, 1500);
              if (approach_d > 65535) approach_d = 65535;
            end else begin
              approach_d = approach_d - reach;
            end
            d = 16'(approach_d);
          end
        endcase
        case ($urandom_range(9))
          0: sc = '0;
          1: sc = '1;
          2, 3: sc = 10'($urandom);
          default: sc = 10'($urandom_range(128, 384));
        endcase
        send_tick(d, sc, $urandom_range(99) < 90, $urandom_range(99) < 4, 1'b0, '0);
      end
      settle();
    end

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
sv/spg_pkg.sv
sv/spg_if.sv
sv/spg_datapath.sv
sv/speed_profile_governor.sv
verif/tb_speed_profile_governor.sv
